FILE: hw/rtl/hgs_pkg.sv
// ----------------------------------------------------------------------------
// hgs_pkg: shared types and constants for the heightmap gradient stream
// Line store geometry, field widths, register codes and the item record
// that passes from the input front end to the gradient stage.
// ----------------------------------------------------------------------------
package hgs_pkg;

	// line store depth (longest row the block supports)
	localparam int MAX_ROW_PIXELS = 512;

	// field and register widths
	localparam int PIX_W = 8;
	localparam int FW_W  = 10;
	localparam int FH_W  = 12;
	localparam int CFG_W = 12;
	localparam int ROW_W = FH_W;

	// column index, and a count that can hold the row length itself
	localparam int COL_W  = $clog2(MAX_ROW_PIXELS);
	localparam int CNT_W  = $clog2(MAX_ROW_PIXELS + 1);
	localparam int WCMP_W = (FW_W > CNT_W) ? FW_W : CNT_W;

	// smallest frame edge, register reset values
	localparam int MIN_DIM  = 3;
	localparam int FW_RESET = 480;
	localparam int FH_RESET = 320;

	typedef logic [PIX_W-1:0]  pix_t;
	typedef logic [COL_W-1:0]  col_t;
	typedef logic [CNT_W-1:0]  cnt_t;
	typedef logic [WCMP_W-1:0] wcmp_t;
	typedef logic [ROW_W-1:0]  row_t;
	typedef logic [FW_W-1:0]   fw_t;
	typedef logic [CFG_W-1:0]  cfg_data_t;

	// configuration register indexes
	typedef enum logic [0:0] {
		REG_FRAME_WIDTH  = 1'b0,
		REG_FRAME_HEIGHT = 1'b1
	} cfg_reg_t;

	// one line store entry: row r-2 and row r-1 at the same column
	typedef struct packed {
		pix_t older;
		pix_t prev;
	} line_t;

	localparam int LINE_W = 2 * PIX_W;

	// one accepted pixel with its position flags
	typedef struct packed {
		pix_t px;
		col_t col;
		logic has_main;
		logic interior;
		logic last_row;
	} item_t;

endpackage

FILE: hw/rtl/hgs_ram.sv
// ----------------------------------------------------------------------------
// hgs_ram: generic line store
// One write port and two read ports, read data registered and held
// while the read enable is low.
// ----------------------------------------------------------------------------
module hgs_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 512,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr_a,
	input  logic [AW-1:0]    raddr_b,
	output logic [WIDTH-1:0] rdata_a,
	output logic [WIDTH-1:0] rdata_b
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// write port and registered reads
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_a <= mem_q[raddr_a];
			rdata_b <= mem_q[raddr_b];
		end
	end

endmodule

FILE: hw/rtl/hgs_front.sv
// ----------------------------------------------------------------------------
// hgs_front: input side of the gradient stream
// Holds the frame registers and the raster position, takes input beats,
// issues the line store reads and tags each pixel with its border flags.
// ----------------------------------------------------------------------------
module hgs_front (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_we,
	input  logic [0:0]          cfg_index,
	input  hgs_pkg::cfg_data_t  cfg_data,
	input  logic                in_valid,
	input  hgs_pkg::pix_t       height,
	input  logic                s1_ready,
	output logic                in_stall,
	output logic                accept,
	output hgs_pkg::item_t      item,
	output hgs_pkg::col_t       rd_addr_a,
	output hgs_pkg::col_t       rd_addr_b
);

	hgs_pkg::fw_t   fw_q;
	hgs_pkg::row_t  fh_q;
	hgs_pkg::col_t  col_q;
	hgs_pkg::row_t  row_q;
	hgs_pkg::wcmp_t fw_ext;
	hgs_pkg::cnt_t  eff_w;
	hgs_pkg::row_t  eff_h;
	hgs_pkg::cnt_t  col_inc;
	logic           row_end;
	logic           frame_end;

	// clamp the frame registers to the usable range
	always_comb begin
		fw_ext = hgs_pkg::wcmp_t'(fw_q);
		if (fw_ext < hgs_pkg::wcmp_t'(hgs_pkg::MIN_DIM)) begin
			eff_w = hgs_pkg::cnt_t'(hgs_pkg::MIN_DIM);
		end else if (fw_ext > hgs_pkg::wcmp_t'(hgs_pkg::MAX_ROW_PIXELS)) begin
			eff_w = hgs_pkg::cnt_t'(hgs_pkg::MAX_ROW_PIXELS);
		end else begin
			eff_w = hgs_pkg::cnt_t'(fw_ext);
		end
		if (fh_q < hgs_pkg::row_t'(hgs_pkg::MIN_DIM)) begin
			eff_h = hgs_pkg::row_t'(hgs_pkg::MIN_DIM);
		end else begin
			eff_h = fh_q;
		end
	end

	// position flags
	assign col_inc   = hgs_pkg::cnt_t'(col_q) + hgs_pkg::cnt_t'(1);
	assign row_end   = (col_inc >= eff_w);
	assign frame_end = (row_q == eff_h - hgs_pkg::row_t'(1));

	// handshake and line store reads at the current and the next column
	assign in_stall  = !s1_ready;
	assign accept    = in_valid && s1_ready;
	assign rd_addr_a = col_q;
	assign rd_addr_b = col_inc[hgs_pkg::COL_W-1:0];

	always_comb begin
		item.px       = height;
		item.col      = col_q;
		item.has_main = (row_q != '0);
		item.interior = (row_q >= hgs_pkg::row_t'(2)) && (col_q != '0) && (col_inc < eff_w);
		item.last_row = frame_end;
	end

	// frame registers and raster position; a register write restarts the frame
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fw_q  <= hgs_pkg::fw_t'(hgs_pkg::FW_RESET);
			fh_q  <= hgs_pkg::row_t'(hgs_pkg::FH_RESET);
			col_q <= '0;
			row_q <= '0;
		end else if (cfg_we) begin
			case (hgs_pkg::cfg_reg_t'(cfg_index))
				hgs_pkg::REG_FRAME_WIDTH: begin
					fw_q <= cfg_data[hgs_pkg::FW_W-1:0];
				end
				hgs_pkg::REG_FRAME_HEIGHT: begin
					fh_q <= cfg_data[hgs_pkg::FH_W-1:0];
				end
				default: begin
					fw_q <= fw_q;
				end
			endcase
			col_q <= '0;
			row_q <= '0;
		end else if (accept) begin
			if (row_end) begin
				col_q <= '0;
				row_q <= frame_end ? '0 : row_q + hgs_pkg::row_t'(1);
			end else begin
				col_q <= col_inc[hgs_pkg::COL_W-1:0];
			end
		end
	end

`ifndef SYNTH
	// raster position stays inside the frame in use
	a_col_in_frame: assert property (@(posedge clk) disable iff (!arst_n)
		hgs_pkg::cnt_t'(col_q) < eff_w)
		else $error("column position beyond frame width");

	a_row_in_frame: assert property (@(posedge clk) disable iff (!arst_n)
		row_q < eff_h)
		else $error("row position beyond frame height");
`endif

endmodule

FILE: hw/rtl/hgs_calc.sv
// ----------------------------------------------------------------------------
// hgs_calc: gradient stage and output register
// Combines the line store read data with the held pixel, writes the shifted
// rows back, and issues up to two result beats per pixel (none for a top-row pixel).
// ----------------------------------------------------------------------------
module hgs_calc (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            accept,
	input  hgs_pkg::item_t  item_in,
	input  hgs_pkg::line_t  line_a,
	input  hgs_pkg::line_t  line_b,
	input  logic            out_stall,
	output logic            s1_ready,
	output logic            ram_we,
	output hgs_pkg::col_t   ram_waddr,
	output hgs_pkg::line_t  ram_wdata,
	output logic            out_valid,
	output hgs_pkg::pix_t   x_gradient,
	output hgs_pkg::pix_t   y_gradient,
	output logic            run_last
);

	logic           valid_s1;
	hgs_pkg::item_t item_s1;
	logic           main_done_s1;
	hgs_pkg::pix_t  prev_left_q;
	logic           out_valid_q;
	hgs_pkg::pix_t  gx_q;
	hgs_pkg::pix_t  gy_q;
	logic           last_q;
	logic           emit_main;
	logic           emit_zero;
	logic           emit_final;
	logic           out_free;
	logic           out_load;
	logic           s1_done;
	hgs_pkg::pix_t  gx;
	hgs_pkg::pix_t  gy;

	// which result beat is pending for the held pixel
	assign emit_main  = valid_s1 && item_s1.has_main && !main_done_s1;
	assign emit_zero  = valid_s1 && !emit_main && item_s1.last_row;
	assign emit_final = emit_zero || (emit_main && !item_s1.last_row);
	assign out_free   = !out_valid_q || !out_stall;
	assign out_load   = (emit_main || emit_zero) && out_free;
	assign s1_done    = valid_s1 && ((!emit_main && !emit_zero) || (out_free && emit_final));
	assign s1_ready   = !valid_s1 || s1_done;

	// central differences, wrapped to pixel width
	assign gx = prev_left_q - line_b.prev;
	assign gy = line_a.older - item_s1.px;

	// shift rows in the line store once the pixel retires
	assign ram_we          = s1_done;
	assign ram_waddr       = item_s1.col;
	assign ram_wdata.older = line_a.prev;
	assign ram_wdata.prev  = item_s1.px;

	// stage control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1     <= 1'b0;
			main_done_s1 <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			if (s1_ready) begin
				valid_s1 <= accept;
			end
			if (s1_done || !valid_s1) begin
				main_done_s1 <= 1'b0;
			end else if (out_load && emit_main) begin
				main_done_s1 <= 1'b1;
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// stage payload, left neighbor of the previous row, result beat
	always_ff @(posedge clk) begin
		if (accept && s1_ready) begin
			item_s1 <= item_in;
		end
		if (s1_done) begin
			prev_left_q <= line_a.prev;
		end
		if (out_load) begin
			if (emit_main && item_s1.interior) begin
				gx_q <= gx;
				gy_q <= gy;
			end else begin
				gx_q <= '0;
				gy_q <= '0;
			end
			last_q <= emit_final;
		end
	end

	assign out_valid  = out_valid_q;
	assign x_gradient = gx_q;
	assign y_gradient = gy_q;
	assign run_last   = last_q;

`ifndef SYNTH
	// the second beat is only pending for a bottom-row pixel
	a_split_last_row: assert property (@(posedge clk) disable iff (!arst_n)
		main_done_s1 |-> valid_s1 && item_s1.has_main && item_s1.last_row)
		else $error("split result on a pixel outside the bottom row");

	a_split_after_load: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(main_done_s1) |-> $past(out_load))
		else $error("first result marked done without an output load");
`endif

endmodule

FILE: hw/rtl/heightmap_gradient_stream.sv
// ----------------------------------------------------------------------------
// heightmap_gradient_stream: streaming central-difference heightmap gradient
// Result order: a result beat passes the stage register and then the output
//   register after the beat of the next row's pixel at the same column is
//   accepted; a bottom-row pixel's own zero beat follows its first beat.
// Throughput: one pixel per cycle while out_stall is low; a bottom-row pixel
//   holds the stage until the single output register has issued both results.
// Reset: frame width 480, height 320, position at the frame start; the line
//   store keeps no reset and needs no clearing pass.
// ----------------------------------------------------------------------------
module heightmap_gradient_stream (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic [0:0]         cfg_index,
	input  hgs_pkg::cfg_data_t cfg_data,
	input  logic               in_valid,
	output logic               in_stall,
	input  hgs_pkg::pix_t      height,
	output logic               out_valid,
	input  logic               out_stall,
	output hgs_pkg::pix_t      x_gradient,
	output hgs_pkg::pix_t      y_gradient,
	output logic               run_last
);

	logic           accept;
	logic           s1_ready;
	hgs_pkg::item_t item;
	hgs_pkg::col_t  rd_addr_a;
	hgs_pkg::col_t  rd_addr_b;
	hgs_pkg::line_t line_a;
	hgs_pkg::line_t line_b;
	logic           ram_we;
	hgs_pkg::col_t  ram_waddr;
	hgs_pkg::line_t ram_wdata;

	// raster position, frame registers, read issue
	hgs_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_valid  (in_valid),
		.height    (height),
		.s1_ready  (s1_ready),
		.in_stall  (in_stall),
		.accept    (accept),
		.item      (item),
		.rd_addr_a (rd_addr_a),
		.rd_addr_b (rd_addr_b)
	);

	// two previous rows, one entry per column
	hgs_ram #(
		.WIDTH (hgs_pkg::LINE_W),
		.DEPTH (hgs_pkg::MAX_ROW_PIXELS)
	) u_line_ram (
		.clk     (clk),
		.we      (ram_we),
		.waddr   (ram_waddr),
		.wdata   (ram_wdata),
		.re      (accept),
		.raddr_a (rd_addr_a),
		.raddr_b (rd_addr_b),
		.rdata_a (line_a),
		.rdata_b (line_b)
	);

	// gradient stage and result beats
	hgs_calc u_calc (
		.clk        (clk),
		.arst_n     (arst_n),
		.accept     (accept),
		.item_in    (item),
		.line_a     (line_a),
		.line_b     (line_b),
		.out_stall  (out_stall),
		.s1_ready   (s1_ready),
		.ram_we     (ram_we),
		.ram_waddr  (ram_waddr),
		.ram_wdata  (ram_wdata),
		.out_valid  (out_valid),
		.x_gradient (x_gradient),
		.y_gradient (y_gradient),
		.run_last   (run_last)
	);

`ifndef SYNTH
	// a write-back never lands on an entry read in the same cycle
	a_no_rw_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		ram_we && accept |-> (ram_waddr != rd_addr_a) && (ram_waddr != rd_addr_b))
		else $error("line store write collides with a read");
`endif

endmodule
